/* rtl/core/sac_pkg.sv */
// Shared constants, codes and types of the set-associative write-back cache.
`timescale 1ns / 1ps
`default_nettype none

package sac_pkg;

    localparam int WAYS_DEF       = 4;
    localparam int WORDS_PER_LINE = 4;
    localparam int SETS           = 64;

    localparam int ADDR_W  = 32;
    localparam int DATA_W  = 32;
    localparam int STAMP_W = 64;
    localparam int OP_W    = 2;
    localparam int POL_W   = 2;

    localparam int OFF_W      = $clog2(WORDS_PER_LINE);
    localparam int SET_W      = $clog2(SETS);
    localparam int WORD_AW    = OFF_W + SET_W;
    localparam int WORD_DEPTH = SETS * WORDS_PER_LINE;
    localparam int TAG_W      = ADDR_W - WORD_AW;

    localparam int S_TDATA_W = ADDR_W + DATA_W;
    localparam int HIT_BIT   = 0;
    localparam int WORD_LSB  = 1;
    localparam int WBA_LSB   = WORD_LSB + DATA_W;
    localparam int M_USED_W  = WBA_LSB + ADDR_W;
    localparam int M_TDATA_W = ((M_USED_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - M_USED_W;

    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK  = 2'd2;
    localparam logic [OP_W-1:0] OP_FILL  = 2'd3;

    localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POL_W-1:0] POL_FIFO  = 2'd1;
    localparam logic [POL_W-1:0] POL_LRU   = 2'd2;
    localparam logic [POL_W-1:0] POL_RR    = 2'd3;
    localparam logic [POL_W-1:0] POL_RESET = POL_LRU;

    localparam logic KIND_ACCESS = 1'b0;
    localparam logic KIND_WB     = 1'b1;

    typedef struct packed {
        logic               modified;
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] load_time;
        logic [STAMP_W-1:0] use_time;
    } meta_t;

    localparam int META_W = $bits(meta_t);

endpackage

`default_nettype wire

/* rtl/core/sac_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module sac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/set_assoc_write_back_cache.sv */
// Top level of the set-associative write-back cache.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+------------------------------------------
//  s_      | in        | s_tvalid/s_tready | tuser operation; tdata address, write_data
//  m_      | out       | m_tvalid/m_tready | tuser response_kind; tlast last_of_run;
//          |           |                   | tdata hit, data_word, writeback_address
//  cfg_    | in        | cfg_valid/ready   | cfg_data replacement_policy
//
// One item per cycle unless s_tready is held low: tag RAMs are read at the input
// transfer, the lookup and all updates sit in the register stage after it, with a
// one-entry write bypass. A fill that evicts a modified line stalls the input while
// the line's words are read back from the word RAM and sent out as write-back words.
// After reset a clearing pass zeroes every word RAM entry; s_tready stays low
// meanwhile. m_tready low holds the output register.
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_write_back_cache #(
    parameter int WAYS = sac_pkg::WAYS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sac_pkg::S_TDATA_W-1:0] s_tdata,   // address, write_data
    input  logic [sac_pkg::OP_W-1:0]      s_tuser,   // operation
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sac_pkg::M_TDATA_W-1:0] m_tdata,   // hit, data_word, writeback_address
    output logic                          m_tuser,   // response_kind
    output logic                          m_tlast,   // last_of_run
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sac_pkg::POL_W-1:0]     cfg_data   // replacement_policy
);

    import sac_pkg::*;

    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

    logic [POL_W-1:0]   policy_reg;
    logic               clr_active_reg;
    logic [WORD_AW-1:0] clr_cnt_reg;

    logic               st_valid_reg;
    logic [OP_W-1:0]    st_op_reg;
    logic [ADDR_W-1:0]  st_addr_reg;
    logic [DATA_W-1:0]  st_data_reg;

    logic [SETS-1:0]    valid_reg [WAYS];
    logic [STAMP_W-1:0] count_reg;
    logic [WAY_W-1:0]   fill_way_reg;

    logic               fwd_meta_valid_reg;
    logic [SET_W-1:0]   fwd_meta_set_reg;
    logic [WAY_W-1:0]   fwd_meta_way_reg;
    meta_t              fwd_meta_reg;
    logic               fwd_word_valid_reg;
    logic [WORD_AW-1:0] fwd_word_addr_reg;
    logic [WAY_W-1:0]   fwd_word_way_reg;
    logic [DATA_W-1:0]  fwd_word_data_reg;

    logic               wb_active_reg;
    logic               wb_data_ok_reg;
    logic [OFF_W-1:0]   wb_cnt_reg;

    logic               m_valid_reg;
    logic               m_kind_reg;
    logic               m_hit_reg;
    logic [DATA_W-1:0]  m_word_reg;
    logic [ADDR_W-1:0]  m_wba_reg;
    logic               m_last_reg;

    logic               accept;
    logic [ADDR_W-1:0]  in_addr;
    logic [SET_W-1:0]   st_set;
    logic [OFF_W-1:0]   st_off;
    logic [TAG_W-1:0]   st_tag;
    logic [WORD_AW-1:0] st_word_addr;

    meta_t              meta_rdata [WAYS];
    logic [DATA_W-1:0]  word_rdata [WAYS];
    meta_t              cur_meta   [WAYS];
    logic [DATA_W-1:0]  cur_word   [WAYS];

    logic               hit_any;
    logic [WAY_W-1:0]   hit_way;
    logic               inv_any;
    logic [WAY_W-1:0]   inv_way;
    logic [WAY_W-1:0]   vic_way;
    logic [WAY_W-1:0]   claim_way;
    logic               st_fill0;
    logic               needs_wb;

    logic               out_free;
    logic               wb_emit;
    logic               wb_last;
    logic               wb_finish;
    logic               wb_start;
    logic [OFF_W-1:0]   wb_cnt_next;
    logic               st_done;
    logic               st_complete;

    logic               meta_we;
    logic [WAY_W-1:0]   meta_way;
    meta_t              meta_wdata;
    logic               word_we;
    logic [WAY_W-1:0]   word_way;
    logic [WORD_AW-1:0] word_waddr;
    logic [DATA_W-1:0]  word_wdata;
    logic               valid_set;
    logic               count_inc;
    logic               acc_load;
    logic [DATA_W-1:0]  acc_word;
    logic [WORD_AW-1:0] word_raddr;
    logic               word_re;

    assign accept       = s_tvalid && s_tready;
    assign in_addr      = s_tdata[ADDR_W-1:0];
    assign st_off       = st_addr_reg[OFF_W-1:0];
    assign st_set       = st_addr_reg[WORD_AW-1:OFF_W];
    assign st_tag       = st_addr_reg[ADDR_W-1:WORD_AW];
    assign st_word_addr = st_addr_reg[WORD_AW-1:0];
    assign cfg_ready    = 1'b1;

    assign word_re    = accept || wb_active_reg;
    assign word_raddr = (wb_active_reg && !wb_finish) ? {st_set, wb_cnt_next}
                                                      : in_addr[WORD_AW-1:0];

    for (genvar g = 0; g < WAYS; g++)
    begin : g_way
        sac_ram #(
            .WIDTH (META_W),
            .DEPTH (SETS)
        ) u_meta_ram (
            .clk   (clk),
            .we    (meta_we && (meta_way == WAY_W'(g))),
            .waddr (st_set),
            .wdata (meta_wdata),
            .re    (accept),
            .raddr (in_addr[WORD_AW-1:OFF_W]),
            .rdata (meta_rdata[g])
        );

        sac_ram #(
            .WIDTH (DATA_W),
            .DEPTH (WORD_DEPTH)
        ) u_word_ram (
            .clk   (clk),
            .we    (clr_active_reg || (word_we && (word_way == WAY_W'(g)))),
            .waddr (clr_active_reg ? clr_cnt_reg : word_waddr),
            .wdata (clr_active_reg ? '0 : word_wdata),
            .re    (word_re),
            .raddr (word_raddr),
            .rdata (word_rdata[g])
        );
    end

    always_comb
    begin
        logic [STAMP_W-1:0] best;
        logic [STAMP_W-1:0] stamp;
        logic [WAY_W-1:0]   pick;
        hit_any = 1'b0;
        hit_way = '0;
        inv_any = 1'b0;
        inv_way = '0;
        best    = '0;
        stamp   = '0;
        pick    = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            cur_meta[w] = (fwd_meta_valid_reg && (fwd_meta_way_reg == WAY_W'(w))
                           && (fwd_meta_set_reg == st_set)) ? fwd_meta_reg : meta_rdata[w];
            cur_word[w] = (fwd_word_valid_reg && (fwd_word_way_reg == WAY_W'(w))
                           && (fwd_word_addr_reg == st_word_addr))
                          ? fwd_word_data_reg : word_rdata[w];
        end
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (valid_reg[w][st_set] && (cur_meta[w].tag == st_tag))
            begin
                hit_any = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!valid_reg[w][st_set])
            begin
                inv_any = 1'b1;
                inv_way = WAY_W'(w);
            end
        end
        case (policy_reg)
            POL_FIFO, POL_LRU:
            begin
                best = '1;
                for (int w = 0; w < WAYS; w++)
                begin
                    stamp = (policy_reg == POL_FIFO) ? cur_meta[w].load_time
                                                     : cur_meta[w].use_time;
                    if (stamp < best)
                    begin
                        best = stamp;
                        pick = WAY_W'(w);
                    end
                end
                vic_way = pick;
            end
            POL_RR:
            begin
                for (int w = 0; w < WAYS; w++)
                begin
                    if (cur_meta[w].use_time > best)
                    begin
                        best = cur_meta[w].use_time;
                        pick = WAY_W'(w);
                    end
                end
                vic_way = (pick == WAY_W'(WAYS - 1)) ? '0 : pick + WAY_W'(1);
            end
            default:
            begin
                vic_way = '0;
            end
        endcase
    end

    assign claim_way = inv_any ? inv_way : vic_way;
    assign st_fill0  = (st_op_reg == OP_FILL) && (st_off == '0);
    assign needs_wb  = st_fill0 && !inv_any && cur_meta[vic_way].modified;

    assign out_free    = !m_valid_reg || m_tready;
    assign wb_emit     = wb_active_reg && wb_data_ok_reg && out_free;
    assign wb_last     = (wb_cnt_reg == OFF_W'(WORDS_PER_LINE - 1));
    assign wb_finish   = wb_emit && wb_last;
    assign wb_cnt_next = wb_emit ? wb_cnt_reg + OFF_W'(1) : wb_cnt_reg;
    assign wb_start    = st_valid_reg && !wb_active_reg && needs_wb;

    always_comb
    begin
        if (st_op_reg != OP_FILL)
        begin
            st_done = out_free;
        end
        else if (st_off != '0)
        begin
            st_done = 1'b1;
        end
        else if (wb_active_reg)
        begin
            st_done = wb_finish;
        end
        else
        begin
            st_done = !needs_wb;
        end
    end

    assign st_complete = st_valid_reg && st_done;
    assign s_tready    = !clr_active_reg && (!st_valid_reg || st_done);

    always_comb
    begin
        meta_we    = 1'b0;
        meta_way   = hit_way;
        meta_wdata = cur_meta[hit_way];
        word_we    = 1'b0;
        word_way   = hit_way;
        word_waddr = st_word_addr;
        word_wdata = st_data_reg;
        valid_set  = 1'b0;
        count_inc  = 1'b0;
        acc_load   = 1'b0;
        acc_word   = '0;
        if (st_complete)
        begin
            case (st_op_reg)
                OP_READ:
                begin
                    count_inc = 1'b1;
                    acc_load  = 1'b1;
                    if (hit_any)
                    begin
                        meta_we             = 1'b1;
                        meta_wdata.use_time = count_reg + STAMP_W'(1);
                        acc_word            = cur_word[hit_way];
                    end
                end
                OP_WRITE:
                begin
                    count_inc = 1'b1;
                    acc_load  = 1'b1;
                    if (hit_any)
                    begin
                        meta_we             = 1'b1;
                        meta_wdata.modified = 1'b1;
                        meta_wdata.use_time = count_reg + STAMP_W'(1);
                        word_we             = 1'b1;
                    end
                end
                OP_PEEK:
                begin
                    acc_load = 1'b1;
                    if (hit_any)
                    begin
                        acc_word = cur_word[hit_way];
                    end
                end
                default:
                begin
                    word_we = 1'b1;
                    if (st_off == '0)
                    begin
                        meta_we              = 1'b1;
                        meta_way             = claim_way;
                        meta_wdata.modified  = 1'b0;
                        meta_wdata.tag       = st_tag;
                        meta_wdata.load_time = count_reg;
                        meta_wdata.use_time  = count_reg;
                        word_way             = claim_way;
                        valid_set            = 1'b1;
                    end
                    else
                    begin
                        word_way = fill_way_reg;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg         <= POL_RESET;
            clr_active_reg     <= 1'b1;
            clr_cnt_reg        <= '0;
            st_valid_reg       <= 1'b0;
            count_reg          <= '0;
            fill_way_reg       <= '0;
            fwd_meta_valid_reg <= 1'b0;
            fwd_word_valid_reg <= 1'b0;
            wb_active_reg      <= 1'b0;
            wb_data_ok_reg     <= 1'b0;
            wb_cnt_reg         <= '0;
            m_valid_reg        <= 1'b0;
            for (int w = 0; w < WAYS; w++)
            begin
                valid_reg[w] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                policy_reg <= cfg_data;
            end

            if (clr_active_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + WORD_AW'(1);
                if (clr_cnt_reg == '1)
                begin
                    clr_active_reg <= 1'b0;
                end
            end

            if (accept)
            begin
                st_valid_reg <= 1'b1;
            end
            else if (st_complete)
            begin
                st_valid_reg <= 1'b0;
            end

            if (count_inc)
            begin
                count_reg <= count_reg + STAMP_W'(1);
            end

            if (valid_set)
            begin
                fill_way_reg <= claim_way;
                for (int w = 0; w < WAYS; w++)
                begin
                    if (claim_way == WAY_W'(w))
                    begin
                        valid_reg[w][st_set] <= 1'b1;
                    end
                end
            end

            if (meta_we)
            begin
                fwd_meta_valid_reg <= 1'b1;
            end
            if (word_we)
            begin
                fwd_word_valid_reg <= 1'b1;
            end

            if (wb_start)
            begin
                wb_active_reg  <= 1'b1;
                wb_data_ok_reg <= 1'b0;
                wb_cnt_reg     <= '0;
            end
            else if (wb_active_reg)
            begin
                wb_cnt_reg     <= wb_cnt_next;
                wb_data_ok_reg <= !wb_finish;
                if (wb_finish)
                begin
                    wb_active_reg <= 1'b0;
                end
            end

            if (acc_load || wb_emit)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            st_op_reg   <= s_tuser;
            st_addr_reg <= in_addr;
            st_data_reg <= s_tdata[S_TDATA_W-1:ADDR_W];
        end
        if (meta_we)
        begin
            fwd_meta_set_reg <= st_set;
            fwd_meta_way_reg <= meta_way;
            fwd_meta_reg     <= meta_wdata;
        end
        if (word_we)
        begin
            fwd_word_addr_reg <= word_waddr;
            fwd_word_way_reg  <= word_way;
            fwd_word_data_reg <= word_wdata;
        end
        if (acc_load)
        begin
            m_kind_reg <= KIND_ACCESS;
            m_hit_reg  <= hit_any;
            m_word_reg <= acc_word;
            m_wba_reg  <= '0;
            m_last_reg <= 1'b1;
        end
        else if (wb_emit)
        begin
            m_kind_reg <= KIND_WB;
            m_hit_reg  <= 1'b0;
            m_word_reg <= word_rdata[vic_way];
            m_wba_reg  <= {cur_meta[vic_way].tag, st_set, wb_cnt_reg};
            m_last_reg <= wb_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_wba_reg, m_word_reg, m_hit_reg};

endmodule

`default_nettype wire

/* rtl/core/sac_check.sv */
// Port-level checks of the cache result channel, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sac_check (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [sac_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tuser,
    input logic                          m_tlast
);

    import sac_pkg::*;

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled transfer changed");

    a_wb_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_WB) |-> !m_tdata[HIT_BIT])
        else $error("write-back word flagged as hit");

    a_access_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_ACCESS)
        |-> m_tlast && (m_tdata[WBA_LSB +: ADDR_W] == '0))
        else $error("access response not a single clean transfer");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_ACCESS) && !m_tdata[HIT_BIT]
        |-> (m_tdata[WORD_LSB +: DATA_W] == '0))
        else $error("miss response carries data");

endmodule

bind set_assoc_write_back_cache sac_check u_sac_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

/* tb/sv/set_assoc_write_back_cache_checker.sv */
// Response predictor and transfer checker for the set-associative write-back cache.
`timescale 1ns / 1ps

module set_assoc_write_back_cache_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [sac_pkg::S_TDATA_W-1:0] s_tdata,   // address, write_data
    input  logic [sac_pkg::OP_W-1:0]      s_tuser,   // operation
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [sac_pkg::M_TDATA_W-1:0] m_tdata,   // hit, data_word, writeback_address
    input  logic                          m_tuser,   // response_kind
    input  logic                          m_tlast,   // last_of_run
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [sac_pkg::POL_W-1:0]     cfg_data,  // replacement_policy
    output int                            errors,
    output int                            outstanding
);

    import sac_pkg::*;

    localparam int CACHE_WAYS  = WAYS_DEF;
    localparam int LINES       = SETS * CACHE_WAYS;

    typedef struct packed {
        logic              kind;
        logic              hit;
        logic [DATA_W-1:0] word;
        logic [ADDR_W-1:0] wb_addr;
        logic              last;
    } cache_resp_t;

    logic               line_valid    [LINES];
    logic               line_modified [LINES];
    logic [TAG_W-1:0]   line_tag      [LINES];
    logic [STAMP_W-1:0] line_load     [LINES];
    logic [STAMP_W-1:0] line_use      [LINES];
    logic [DATA_W-1:0]  line_word     [LINES * WORDS_PER_LINE];
    logic [STAMP_W-1:0] access_count;
    int unsigned        fill_way;
    logic [POL_W-1:0]   policy;
    cache_resp_t        pending_responses[$];
    cache_resp_t        oldest_resp;

    function automatic int unsigned choose_victim(int unsigned base);
        int unsigned        pick;
        int unsigned        w;
        logic [STAMP_W-1:0] best;
        logic [STAMP_W-1:0] stamp;
        pick = 0;
        case (policy)
            POL_FIFO, POL_LRU:
            begin
                best = '1;
                for (w = 0; w < CACHE_WAYS; w++)
                begin
                    stamp = (policy == POL_FIFO) ? line_load[base + w] : line_use[base + w];
                    if (stamp < best)
                    begin
                        best = stamp;
                        pick = w;
                    end
                end
            end
            POL_RR:
            begin
                best = '0;
                for (w = 0; w < CACHE_WAYS; w++)
                begin
                    if (line_use[base + w] > best)
                    begin
                        best = line_use[base + w];
                        pick = w;
                    end
                end
                pick = (pick + 1) % CACHE_WAYS;
            end
            default: pick = 0;
        endcase
        return pick;
    endfunction

    task automatic predict_responses(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                                     logic [DATA_W-1:0] data);
        int unsigned      off;
        int unsigned      base;
        int unsigned      way;
        int unsigned      ln;
        int unsigned      w;
        int unsigned      i;
        int               hit_way;
        logic [TAG_W-1:0] tag;
        off  = addr[OFF_W-1:0];
        base = addr[WORD_AW-1:OFF_W] * CACHE_WAYS;
        tag  = addr[ADDR_W-1:WORD_AW];
        if (op != OP_FILL)
        begin
            if (op != OP_PEEK)
                access_count++;
            hit_way = -1;
            for (w = 0; w < CACHE_WAYS; w++)
                if (hit_way < 0 && line_valid[base + w] && line_tag[base + w] == tag)
                    hit_way = w;
            if (hit_way < 0)
            begin
                pending_responses.push_back(cache_resp_t'{KIND_ACCESS, 1'b0, '0, '0, 1'b1});
                return;
            end
            ln = base + hit_way;
            if (op == OP_WRITE)
            begin
                line_word[ln * WORDS_PER_LINE + off] = data;
                line_modified[ln] = 1'b1;
                line_use[ln] = access_count;
                pending_responses.push_back(cache_resp_t'{KIND_ACCESS, 1'b1, '0, '0, 1'b1});
            end
            else
            begin
                if (op == OP_READ)
                    line_use[ln] = access_count;
                pending_responses.push_back(cache_resp_t'{KIND_ACCESS, 1'b1,
                    line_word[ln * WORDS_PER_LINE + off], '0, 1'b1});
            end
            return;
        end
        if (off == 0)
        begin
            way = CACHE_WAYS;
            for (w = 0; w < CACHE_WAYS; w++)
                if (way == CACHE_WAYS && !line_valid[base + w])
                    way = w;
            if (way == CACHE_WAYS)
            begin
                way = choose_victim(base);
                ln  = base + way;
                if (line_modified[ln])
                    for (i = 0; i < WORDS_PER_LINE; i++)
                        pending_responses.push_back(cache_resp_t'{KIND_WB, 1'b0,
                            line_word[ln * WORDS_PER_LINE + i],
                            {line_tag[ln], addr[WORD_AW-1:OFF_W], OFF_W'(i)},
                            i == WORDS_PER_LINE - 1});
            end
            fill_way = way;
            ln = base + way;
            line_valid[ln]    = 1'b1;
            line_modified[ln] = 1'b0;
            line_load[ln]     = access_count;
            line_use[ln]      = access_count;
            line_tag[ln]      = tag;
        end
        line_word[(base + fill_way) * WORDS_PER_LINE + off] = data;
    endtask

    task automatic check_field(string field, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s expected %h, actual %h", $time, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            policy       = POL_RESET;
            access_count = '0;
            fill_way     = 0;
            foreach (line_valid[i])
            begin
                line_valid[i]    = 1'b0;
                line_modified[i] = 1'b0;
                line_tag[i]      = '0;
                line_load[i]     = '0;
                line_use[i]      = '0;
            end
            foreach (line_word[i])
                line_word[i] = '0;
            pending_responses.delete();
            errors = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                policy = cfg_data;
            if (s_tvalid && s_tready)
                predict_responses(s_tuser, s_tdata[ADDR_W-1:0], s_tdata[S_TDATA_W-1:ADDR_W]);
            if (m_tvalid && m_tready)
            begin
                if (pending_responses.size() == 0)
                begin
                    errors++;
                    $display("%0t: response expected none, actual kind %h tdata %h last %h",
                             $time, m_tuser, m_tdata, m_tlast);
                end
                else
                begin
                    oldest_resp = pending_responses.pop_front();
                    check_field("response_kind", oldest_resp.kind, m_tuser);
                    check_field("hit", oldest_resp.hit, m_tdata[HIT_BIT]);
                    check_field("data_word", oldest_resp.word, m_tdata[WORD_LSB +: DATA_W]);
                    check_field("writeback_address", oldest_resp.wb_addr,
                                m_tdata[WBA_LSB +: ADDR_W]);
                    check_field("last_of_run", oldest_resp.last, m_tlast);
                    check_field("tdata padding", '0, m_tdata[M_TDATA_W-1:M_USED_W]);
                end
            end
            outstanding <= pending_responses.size();
        end
    end

endmodule

/* tb/sv/set_assoc_write_back_cache_tb.sv */
// Stimulus, handshake pacing and verdict for the set-associative write-back cache.
`timescale 1ns / 1ps

module set_assoc_write_back_cache_tb;
    import sac_pkg::*;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 56;
    localparam int SETTLE_CYCLES  = WORDS_PER_LINE + 12;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAG_POOL       = 6;
    localparam int SET_POOL       = 4;
    localparam logic [POL_W-1:0] PHASE_POLICY [RANDOM_PHASES] =
        '{POL_FIRST, POL_RR, POL_FIFO, POL_LRU, POL_RR, POL_FIRST, POL_LRU, POL_FIFO};

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;   // address, write_data
    logic [OP_W-1:0]      s_tuser   = OP_READ;   // operation
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;   // hit, data_word, writeback_address
    logic                 m_tuser;   // response_kind
    logic                 m_tlast;   // last_of_run
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [POL_W-1:0]     cfg_data  = POL_RESET;   // replacement_policy
    int                   errors;
    int                   outstanding;

    idle_mode_t           idle_mode    = IDLE_NONE;
    logic                 hold_req     = 1'b0;
    logic                 hold_done    = 1'b0;
    int                   hold_left    = 0;
    int                   quiet_cycles = 0;
    int                   items_sent   = 0;
    logic [TAG_W-1:0]     tag_pool [TAG_POOL];
    logic [SET_W-1:0]     set_pool [SET_POOL];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    set_assoc_write_back_cache #(.WAYS(WAYS_DEF)) u_dut (.*);

    set_assoc_write_back_cache_checker u_checker (.*);

    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_done)
        begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
        begin
            case (idle_mode)
                IDLE_RECEIVER: m_tready <= ($urandom_range(99) >= 66);
                IDLE_BOTH:     m_tready <= ($urandom_range(99) >= 17);
                default:       m_tready <= 1'b1;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("set_assoc_write_back_cache: mismatch");
            $finish;
        end
    end

    task automatic send_item(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                             logic [DATA_W-1:0] data);
        int unsigned gap_pct;
        gap_pct = (idle_mode == IDLE_SENDER) ? 66 : (idle_mode == IDLE_BOTH) ? 17 : 0;
        while ($urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {data, addr};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_fill_run(logic [ADDR_W-1:0] line_addr, int first_off, int count);
        int off;
        for (off = first_off; off < first_off + count && off < WORDS_PER_LINE; off++)
            send_item(OP_FILL, line_addr | ADDR_W'(off), $urandom());
    endtask

    // Drop valid, wait out every outstanding response, then let the pipeline settle.
    task automatic drain_responses();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_policy(logic [POL_W-1:0] value);
        drain_responses();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_burst();
        int unsigned       pick;
        logic [ADDR_W-1:0] line_addr;
        pick      = $urandom_range(99);
        line_addr = {tag_pool[$urandom_range(TAG_POOL - 1)],
                     set_pool[$urandom_range(SET_POOL - 1)], OFF_W'(0)};
        if (pick < 30)
            send_fill_run(line_addr, 0, WORDS_PER_LINE);
        else if (pick < 85)
            send_item(OP_W'($urandom_range(OP_READ, OP_PEEK)),
                      line_addr | ADDR_W'($urandom_range(WORDS_PER_LINE - 1)), $urandom());
        else if (pick < 93)
            send_fill_run(line_addr, $urandom_range(WORDS_PER_LINE - 1),
                          $urandom_range(1, WORDS_PER_LINE - 1));
        else
            send_item(OP_W'($urandom_range(OP_READ, OP_FILL)), $urandom(), $urandom());
    endtask

    initial
    begin
        int phase;
        int phase_end;
        foreach (tag_pool[i])
            tag_pool[i] = TAG_W'($urandom());
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        set_pool[0] = '0;
        set_pool[1] = '1;
        set_pool[2] = SET_W'($urandom());
        set_pool[3] = SET_W'($urandom());
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_item(OP_READ, '0, '1);
        send_item(OP_PEEK, '1, '0);
        send_fill_run('0, 0, 0);
        send_item(OP_FILL, 32'h0000_0000, 32'h0000_0000);
        send_item(OP_FILL, 32'h0000_0001, 32'hFFFF_FFFF);
        send_item(OP_FILL, 32'h0000_0002, 32'h8000_0001);
        send_item(OP_FILL, 32'h0000_0003, 32'h7FFF_FFFE);
        send_item(OP_WRITE, 32'h0000_0001, 32'hA5A5_5A5A);
        send_item(OP_READ, 32'h0000_0001, '0);
        send_item(OP_PEEK, 32'h0000_0002, '1);
        send_item(OP_WRITE, '1, '1);
        // nonzero offset with no line claimed before it
        send_item(OP_FILL, '1, 32'h1234_5678);
        send_item(OP_FILL, {TAG_W'(1), SET_W'(0), OFF_W'(0)}, $urandom());
        send_item(OP_FILL, {TAG_W'(2), SET_W'(0), OFF_W'(0)}, $urandom());
        send_item(OP_FILL, {TAG_W'(3), SET_W'(0), OFF_W'(0)}, $urandom());
        // full set: the modified line goes back to memory
        send_item(OP_FILL, {{TAG_W{1'b1}}, SET_W'(0), OFF_W'(0)}, '1);
        send_item(OP_READ, 32'h0000_0001, '0);
        send_item(OP_PEEK, '1, '0);

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            write_policy(PHASE_POLICY[phase]);
            idle_mode = idle_mode_t'(phase % 4);
            if (phase == 0)
                hold_req <= 1'b1;
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
                send_random_burst();
        end

        drain_responses();
        if (errors == 0)
            $display("set_assoc_write_back_cache: match");
        else
            $display("set_assoc_write_back_cache: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/sac_pkg.sv
rtl/core/sac_ram.sv
rtl/core/set_assoc_write_back_cache.sv
rtl/core/sac_check.sv
tb/sv/set_assoc_write_back_cache_checker.sv
tb/sv/set_assoc_write_back_cache_tb.sv
